>>> rtl/sto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_pkg: shared types and constants of the sigma threshold outlier selector
// Item and result layouts, sequencer states, microprogram steps and the
// command that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package sto_pkg;

  localparam int SCORE_W    = 24;
  localparam int ID_W       = 32;
  localparam int RANK_W     = 4;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_REPORT = 10;

  // Arithmetic widths cover sets of up to 4096 items.
  localparam int OP_W   = 32;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = 80;
  localparam int ROOT_W = ACC_W / 2;
  localparam int B_W    = 40;
  localparam int THR_W  = 44;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LIMIT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_FACTOR = 1'b1;

  localparam logic [CFG_W-1:0] REPORT_LIMIT_RST     = 4'd10;
  localparam logic [CFG_W-1:0] DEVIATION_FACTOR_RST = 4'd2;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           node_id;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [ID_W-1:0]           out_vertex;
    logic signed [SCORE_W-1:0] out_score;
    logic [RANK_W-1:0]         rank;
    logic                      final_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_RD,
    ST_PROD,
    ST_CMP,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // Setup microprogram: k*k, k*k*n, k*|S| in two halves, k*k*n*Q in two
  // halves, then the square of k*|S| in three partial products.
  typedef enum logic [3:0] {
    STEP_KK,
    STEP_K2N,
    STEP_KA0,
    STEP_KA1,
    STEP_NQ0,
    STEP_NQ1,
    STEP_B00,
    STEP_B01,
    STEP_B11
  } step_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_33,
    SH_64
  } acc_sh_t;

  typedef struct packed {
    logic            mul_en;
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
    acc_op_t         acc_op;
    acc_sh_t         acc_sh;
  } mac_cmd_t;

endpackage

>>> rtl/sigma_threshold_outlier_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_threshold_outlier_select: mean plus k sigma outlier selector
// Collects a set of scored items and reports, in arrival order, those whose
// score lies more than k standard deviations above the set mean.
// ----------------------------------------------------------------------------
// Items load at one per cycle into two RAMs while the count, sum and sum of
// squares are kept. The item marked last closes the set; the block then stops
// taking items. Setup runs nine products through the shared 32 x 32 multiplier,
// each in a multiply state and an accumulate state, to form k*k*(n*Q - S*S),
// and the root unit turns that bound into a threshold for n times the score.
// The scan then takes each stored item through a RAM read, a multiply by n and
// a compare, and holds at the compare while an outlier waits for the result
// slot; a read state that finds no entry left ends the scan, and the flush and
// done states close the set. The scan ends early once report_limit (zero taken
// as one, at most MAX_REPORT) outliers are found. The stores have no reset and
// need no clearing pass: only entries written in the current set are read.
// ----------------------------------------------------------------------------
module sigma_threshold_outlier_select #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  sto_pkg::in_item_t                   item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output sto_pkg::out_item_t                  result,
  input  logic                                cfg_we,
  input  logic [sto_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sto_pkg::CFG_W-1:0]           cfg_data
);
  import sto_pkg::*;

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int SW    = SCORE_W + AW;
  localparam int QW    = 2 * SCORE_W + AW;
  localparam int SQ_W  = 2 * SCORE_W;
  localparam int K2_W  = 2 * CFG_W;
  localparam int K2N_W = K2_W + CW;

  state_t state, state_next;
  step_t  step;

  logic [CFG_W-1:0]  report_limit;
  logic [CFG_W-1:0]  deviation_factor;
  logic [RANK_W-1:0] lim;

  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic signed [SW-1:0]   score_sum;
  logic [QW-1:0]          square_sum;
  logic [SQ_W-1:0]        sq_pend;
  logic                   sq_pend_valid;

  logic [K2_W-1:0]         k2;
  logic [K2N_W-1:0]        k2n;
  logic [B_W-1:0]          bval;
  logic signed [THR_W-1:0] thr;

  logic                      pend_valid;
  logic [ID_W-1:0]           pend_id;
  logic signed [SCORE_W-1:0] pend_score;
  logic [RANK_W-1:0]         pend_rank;
  logic [RANK_W-1:0]         rank_cnt;

  logic accept;
  logic store;
  logic slot_free;
  logic qual;
  logic take;

  logic [SCORE_W-1:0] in_mag;
  logic [SW-1:0]      abs_sum;
  logic [PROD_W-1:0]  a_ext;
  logic [PROD_W-1:0]  q_ext;

  mac_cmd_t           mac_cmd;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc;
  logic               root_start;
  logic               root_done;
  logic [ROOT_W-1:0]  root;

  logic               ram_re;
  logic [SCORE_W-1:0] score_rdata;
  logic [ID_W-1:0]    id_rdata;
  logic [SCORE_W-1:0] rd_mag;
  logic signed [THR_W-1:0] prod_s;

  logic      emit;
  out_item_t emit_item;

  // ---------------------------------------------------------------- datapath
  assign item_ready = (state == ST_LOAD);
  assign accept     = item_valid && item_ready;
  assign store      = accept && (count != CW'(MAX_ITEMS));
  assign slot_free  = !result_valid || result_ready;

  assign in_mag  = item.score[SCORE_W-1] ? SCORE_W'(-item.score) : SCORE_W'(item.score);
  assign abs_sum = score_sum[SW-1] ? SW'(-score_sum) : SW'(score_sum);
  assign a_ext   = PROD_W'(abs_sum);
  assign q_ext   = PROD_W'(square_sum);

  assign rd_mag = score_rdata[SCORE_W-1] ? SCORE_W'(-score_rdata) : score_rdata;
  assign prod_s = score_rdata[SCORE_W-1] ? -$signed(prod[THR_W-1:0])
                                         : $signed(prod[THR_W-1:0]);
  // n*s - S > floor(sqrt(bound)) is the same test as the squared form.
  assign qual = (prod_s > thr);
  assign take = (state == ST_CMP) && qual && !(pend_valid && !slot_free);

  always_comb begin
    priority if (report_limit == '0) begin
      lim = RANK_W'(1);
    end else if (report_limit > CFG_W'(MAX_REPORT)) begin
      lim = RANK_W'(MAX_REPORT);
    end else begin
      lim = RANK_W'(report_limit);
    end
  end

  sto_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_ITEMS)) u_score_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (item.score),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (score_rdata)
  );

  sto_ram #(.WIDTH(ID_W), .DEPTH(MAX_ITEMS)) u_id_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (item.node_id),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (id_rdata)
  );

  sto_mac u_mac (
    .clk  (clk),
    .cmd  (mac_cmd),
    .prod (prod),
    .acc  (acc)
  );

  sto_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (acc),
    .done  (root_done),
    .root  (root)
  );

  // -------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && item.last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        state_next = (step == STEP_B11) ? ST_ROOT_GO : ST_MUL;
      end
      ST_ROOT_GO: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (root_done) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = (idx == count) ? ST_FLUSH : ST_PROD;
      end
      ST_PROD: state_next = ST_CMP;
      ST_CMP: begin
        priority if (!qual) begin
          state_next = ST_RD;
        end else if (!take) begin
          state_next = ST_CMP;
        end else if (RANK_W'(rank_cnt + 1'b1) == lim) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- controls
  always_comb begin
    mac_cmd    = '{mul_en: 1'b0, a: '0, b: '0, acc_op: ACC_HOLD, acc_sh: SH_0};
    ram_re     = 1'b0;
    root_start = 1'b0;
    emit       = 1'b0;
    emit_item  = '0;
    unique case (state)
      ST_MUL: begin
        mac_cmd.mul_en = 1'b1;
        unique case (step)
          STEP_KK:  begin
            mac_cmd.a = OP_W'(deviation_factor);
            mac_cmd.b = OP_W'(deviation_factor);
          end
          STEP_K2N: begin
            mac_cmd.a = OP_W'(k2);
            mac_cmd.b = OP_W'(count);
          end
          STEP_KA0: begin
            mac_cmd.a = OP_W'(deviation_factor);
            mac_cmd.b = a_ext[OP_W-1:0];
          end
          STEP_KA1: begin
            mac_cmd.a = OP_W'(deviation_factor);
            mac_cmd.b = a_ext[PROD_W-1:OP_W];
          end
          STEP_NQ0: begin
            mac_cmd.a = OP_W'(k2n);
            mac_cmd.b = q_ext[OP_W-1:0];
          end
          STEP_NQ1: begin
            mac_cmd.a = OP_W'(k2n);
            mac_cmd.b = q_ext[PROD_W-1:OP_W];
          end
          STEP_B00: begin
            mac_cmd.a = bval[OP_W-1:0];
            mac_cmd.b = bval[OP_W-1:0];
          end
          STEP_B01: begin
            mac_cmd.a = bval[OP_W-1:0];
            mac_cmd.b = OP_W'(bval[B_W-1:OP_W]);
          end
          STEP_B11: begin
            mac_cmd.a = OP_W'(bval[B_W-1:OP_W]);
            mac_cmd.b = OP_W'(bval[B_W-1:OP_W]);
          end
          default: begin
            mac_cmd.a = '0;
            mac_cmd.b = '0;
          end
        endcase
      end
      ST_ACC: begin
        unique case (step)
          STEP_KA0: begin
            mac_cmd.acc_op = ACC_LOAD;
            mac_cmd.acc_sh = SH_0;
          end
          STEP_KA1: begin
            mac_cmd.acc_op = ACC_ADD;
            mac_cmd.acc_sh = SH_32;
          end
          STEP_NQ0: begin
            mac_cmd.acc_op = ACC_LOAD;
            mac_cmd.acc_sh = SH_0;
          end
          STEP_NQ1: begin
            mac_cmd.acc_op = ACC_ADD;
            mac_cmd.acc_sh = SH_32;
          end
          STEP_B00: begin
            mac_cmd.acc_op = ACC_SUB;
            mac_cmd.acc_sh = SH_0;
          end
          // The cross term appears twice, hence the extra bit of shift.
          STEP_B01: begin
            mac_cmd.acc_op = ACC_SUB;
            mac_cmd.acc_sh = SH_33;
          end
          STEP_B11: begin
            mac_cmd.acc_op = ACC_SUB;
            mac_cmd.acc_sh = SH_64;
          end
          default: begin
            mac_cmd.acc_op = ACC_HOLD;
            mac_cmd.acc_sh = SH_0;
          end
        endcase
      end
      ST_ROOT_GO: root_start = 1'b1;
      ST_RD: ram_re = (idx != count);
      ST_PROD: begin
        mac_cmd.mul_en = 1'b1;
        mac_cmd.a      = OP_W'(rd_mag);
        mac_cmd.b      = OP_W'(count);
      end
      ST_CMP: begin
        if (take && pend_valid) begin
          emit      = 1'b1;
          emit_item = '{found: 1'b1, out_vertex: pend_id, out_score: pend_score,
                        rank: pend_rank, final_res: 1'b0};
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pend_valid) begin
            emit_item = '{found: 1'b1, out_vertex: pend_id, out_score: pend_score,
                          rank: pend_rank, final_res: 1'b1};
          end else begin
            emit_item.final_res = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      report_limit     <= REPORT_LIMIT_RST;
      deviation_factor <= DEVIATION_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPORT_LIMIT:     report_limit     <= cfg_data;
        CFG_DEVIATION_FACTOR: deviation_factor <= cfg_data;
        default:              report_limit     <= report_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      step          <= STEP_KK;
      count         <= '0;
      idx           <= '0;
      score_sum     <= '0;
      square_sum    <= '0;
      sq_pend_valid <= 1'b0;
      pend_valid    <= 1'b0;
      rank_cnt      <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // Squares go through a register and are added in the cycle after the item is taken.
      sq_pend_valid <= store;
      if (store) begin
        count     <= count + 1'b1;
        score_sum <= score_sum + SW'(item.score);
        sq_pend   <= SQ_W'(in_mag) * SQ_W'(in_mag);
      end
      if (sq_pend_valid) begin
        square_sum <= square_sum + QW'(sq_pend);
      end

      if (state == ST_ACC) begin
        unique case (step)
          STEP_KK:  k2   <= prod[K2_W-1:0];
          STEP_K2N: k2n  <= prod[K2N_W-1:0];
          STEP_NQ0: bval <= acc[B_W-1:0];
          default:  k2   <= k2;
        endcase
        step <= (step == STEP_B11) ? STEP_KK : step_t'(4'(step) + 4'd1);
      end

      if (state == ST_ROOT_WAIT && root_done) begin
        thr <= $signed({{(THR_W - SW){score_sum[SW-1]}}, score_sum})
             + $signed({{(THR_W - ROOT_W){1'b0}}, root});
        idx        <= '0;
        rank_cnt   <= '0;
        pend_valid <= 1'b0;
      end

      if (state == ST_CMP && (!qual || take)) begin
        idx <= idx + 1'b1;
      end
      if (take) begin
        pend_valid <= 1'b1;
        pend_id    <= id_rdata;
        pend_score <= score_rdata;
        pend_rank  <= rank_cnt;
        rank_cnt   <= rank_cnt + 1'b1;
      end

      if (state == ST_DONE) begin
        count      <= '0;
        score_sum  <= '0;
        square_sum <= '0;
        pend_valid <= 1'b0;
      end

      if (emit) begin
        result_valid <= 1'b1;
        result       <= emit_item;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_scan_in_set: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> idx < count)
    else $error("scan compares an entry outside the current set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count beyond store depth");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.rank < RANK_W'(MAX_REPORT))
    else $error("outlier rank beyond report limit");

  a_none_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.final_res && result.rank == '0)
    else $error("empty result not marked as the last of its set");
`endif

endmodule

>>> rtl/sto_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read enable.
// ----------------------------------------------------------------------------
module sto_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sto_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_mac: shared multiply-accumulate unit
// A registered 32 x 32 unsigned multiplier followed by a shifting
// accumulator that loads, adds or subtracts the previous product.
// ----------------------------------------------------------------------------
module sto_mac (
  input  logic                             clk,
  input  sto_pkg::mac_cmd_t                cmd,
  output logic [sto_pkg::PROD_W-1:0]       prod,
  output logic [sto_pkg::ACC_W-1:0]        acc
);
  import sto_pkg::*;

  logic [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0] shifted;

  assign prod_ext = ACC_W'(prod);

  always_comb begin
    unique case (cmd.acc_sh)
      SH_0:    shifted = prod_ext;
      SH_32:   shifted = prod_ext << 32;
      SH_33:   shifted = prod_ext << 33;
      SH_64:   shifted = prod_ext << 64;
      default: shifted = prod_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(cmd.a) * PROD_W'(cmd.b);
    end
    unique case (cmd.acc_op)
      ACC_HOLD: acc <= acc;
      ACC_LOAD: acc <= shifted;
      ACC_ADD:  acc <= acc + shifted;
      ACC_SUB:  acc <= acc - shifted;
      default:  acc <= acc;
    endcase
  end

endmodule

>>> rtl/sto_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_isqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle; gives the floor
// of the square root of an unsigned word.
// ----------------------------------------------------------------------------
module sto_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sto_pkg::ACC_W-1:0]   value,
  output logic                        done,
  output logic [sto_pkg::ROOT_W-1:0]  root
);
  import sto_pkg::*;

  localparam int IT_W = $clog2(ROOT_W + 1);

  logic            running;
  logic [IT_W-1:0] iter;
  logic [ACC_W-1:0] val_sr;
  logic [ROOT_W-1:0] rem;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_sh = {rem, val_sr[ACC_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= IT_W'(ROOT_W);
        val_sr  <= value;
        rem     <= '0;
        root    <= '0;
      end else if (running) begin
        val_sr <= val_sr << 2;
        // The remainder stays below twice the partial root, so its top bits
        // are only lost on the final step, where it is no longer needed.
        rem    <= ge ? ROOT_W'(rem_sh - trial) : ROOT_W'(rem_sh);
        root   <= {root[ROOT_W-2:0], ge};
        iter   <= iter - 1'b1;
        if (iter == IT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> verif/outlier_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outlier_report_checker: scoreboard for the sigma threshold outlier selector
// Watches the item, result and register ports, recomputes each closed set's
// mean plus k sigma outliers with exact wide integers, and compares every
// result with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module outlier_report_checker #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  sto_pkg::in_item_t               item,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  sto_pkg::out_item_t              result,
  input  logic                            cfg_we,
  input  logic [sto_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sto_pkg::CFG_W-1:0]       cfg_data,
  output int unsigned                     mismatches,
  output int unsigned                     pending,
  output int unsigned                     items_taken,
  output int unsigned                     sets_closed
);
  import sto_pkg::*;

  out_item_t                 expected_reports[$];
  logic signed [SCORE_W-1:0] set_scores [MAX_ITEMS];
  logic [ID_W-1:0]           set_ids    [MAX_ITEMS];
  int unsigned               set_size = 0;
  longint                    set_sum = 0;
  longint unsigned           set_square_sum = 0;
  logic [CFG_W-1:0]          limit_reg = REPORT_LIMIT_RST;
  logic [CFG_W-1:0]          factor_reg = DEVIATION_FACTOR_RST;
  int unsigned               fail_total = 0;
  int unsigned               pending_now = 0;
  int unsigned               taken_total = 0;
  int unsigned               closed_total = 0;
  int unsigned               checked_total = 0;

  assign mismatches  = fail_total;
  assign pending     = pending_now;
  assign items_taken = taken_total;
  assign sets_closed = closed_total;

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, checked_total, what);
    fail_total++;
  endtask

  // Exact test without a root: n*s - S > 0 and (n*s - S)^2 > k^2 (n*Q - S^2).
  task automatic report_outliers();
    logic signed [127:0] n_w;
    logic signed [127:0] sum_w;
    logic signed [127:0] spread_w;
    logic signed [127:0] bound_w;
    logic signed [127:0] dev_w;
    logic signed [127:0] k_w;
    out_item_t           hit;
    int unsigned         cap;
    int unsigned         hits;
    n_w      = set_size;
    sum_w    = set_sum;
    spread_w = set_square_sum;
    spread_w = n_w * spread_w - sum_w * sum_w;
    k_w      = factor_reg;
    bound_w  = k_w * k_w * spread_w;
    if (limit_reg == 0) begin
      cap = 1;
    end else if (limit_reg > MAX_REPORT) begin
      cap = MAX_REPORT;
    end else begin
      cap = limit_reg;
    end
    hits = 0;
    hit  = '0;
    for (int unsigned i = 0; i < set_size && hits < cap; i++) begin
      dev_w = n_w * set_scores[i] - sum_w;
      if (dev_w > 0 && dev_w * dev_w > bound_w) begin
        // The previous hit is only known not to be the final one now.
        if (hits != 0) begin
          expected_reports.push_back(hit);
        end
        hit.found      = 1'b1;
        hit.out_vertex = set_ids[i];
        hit.out_score  = set_scores[i];
        hit.rank       = RANK_W'(hits);
        hit.final_res  = 1'b0;
        hits++;
      end
    end
    if (hits == 0) begin
      hit = '0;
    end
    hit.final_res = 1'b1;
    expected_reports.push_back(hit);
    set_size       = 0;
    set_sum        = 0;
    set_square_sum = 0;
    closed_total++;
  endtask

  task automatic absorb_item(input in_item_t it);
    longint value;
    value = $signed(it.score);
    // Once the store is full, further items only count for their last mark.
    if (set_size < MAX_ITEMS) begin
      set_scores[set_size] = it.score;
      set_ids[set_size]    = it.node_id;
      set_sum              = set_sum + value;
      set_square_sum       = set_square_sum + longint'(value * value);
      set_size++;
    end
    taken_total++;
    if (it.last) begin
      report_outliers();
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected result: found %0b vertex %08h score %0d",
                                got.found, got.out_vertex, $signed(got.out_score)));
    end else begin
      want = expected_reports.pop_front();
      if (got.found !== want.found) begin
        report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
      end
      if (got.out_vertex !== want.out_vertex) begin
        report_mismatch($sformatf("out_vertex %08h, expected %08h",
                                  got.out_vertex, want.out_vertex));
      end
      if (got.out_score !== want.out_score) begin
        report_mismatch($sformatf("out_score %0d, expected %0d",
                                  $signed(got.out_score), $signed(want.out_score)));
      end
      if (got.rank !== want.rank) begin
        report_mismatch($sformatf("rank %0d, expected %0d", got.rank, want.rank));
      end
      if (got.final_res !== want.final_res) begin
        report_mismatch($sformatf("final_res %0b, expected %0b", got.final_res,
                                  want.final_res));
      end
    end
    checked_total++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_reports.delete();
      set_size       = 0;
      set_sum        = 0;
      set_square_sum = 0;
      limit_reg      = REPORT_LIMIT_RST;
      factor_reg     = DEVIATION_FACTOR_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_REPORT_LIMIT) begin
          limit_reg = cfg_data;
        end else if (cfg_index == CFG_DEVIATION_FACTOR) begin
          factor_reg = cfg_data;
        end
      end
      if (item_valid && item_ready) begin
        absorb_item(item);
      end
      if (result_valid && result_ready) begin
        check_result(result);
      end
    end
    pending_now = expected_reports.size();
  end

endmodule

>>> verif/sigma_threshold_outlier_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_threshold_outlier_select_tb: top level test of the outlier selector
// Drives scored item sets through the selector under several register
// settings, with random gaps and result stalls, and leaves the checking to
// the outlier report checker beside the block.
// ----------------------------------------------------------------------------
module sigma_threshold_outlier_select_tb;
  import sto_pkg::*;

  localparam int MAX_ITEMS    = 1024;
  localparam int CLOSE_CYCLES = 20;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 20;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_CLUSTER,
    SHAPE_FLAT,
    SHAPE_EXTREME
  } shape_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  in_item_t              item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  out_item_t             result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REPORT_LIMIT;
  logic [CFG_W-1:0]      cfg_data = '0;

  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           items_taken;
  int unsigned           sets_closed;
  int unsigned           settings_used = 1;
  bit                    idle_on = 1'b1;

  sigma_threshold_outlier_select #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  outlier_report_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) scoreboard (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending),
    .items_taken(items_taken),
    .sets_closed(sets_closed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding.", pending);
    $display("sigma_threshold_outlier_select_tb NOT OK");
    $finish;
  end

  always @(negedge clk) begin
    result_ready <= !idle_on || ($urandom_range(0, 99) >= 18);
  end

  function automatic logic signed [SCORE_W-1:0] pick_score(input shape_t shape,
                                                           input int base,
                                                           input int unsigned spike_pct);
    int value;
    case (shape)
      SHAPE_NOISE: begin
        value = $urandom();
      end
      SHAPE_CLUSTER: begin
        value = base + $urandom_range(0, 64) - 32;
        if ($urandom_range(0, 99) < spike_pct) begin
          value = base + $urandom_range(1, 4000000);
        end
      end
      SHAPE_FLAT: begin
        value = base;
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          value = $urandom_range(0, 1000);
        end else if ($urandom_range(0, 1) == 0) begin
          value = SCORE_MAX;
        end else begin
          value = SCORE_MIN;
        end
      end
    endcase
    return value[SCORE_W-1:0];
  endfunction

  // Entered and left just after a falling edge; valid is left high on return.
  task automatic send_item(input logic signed [SCORE_W-1:0] score,
                           input logic [ID_W-1:0] vertex, input logic last);
    while (idle_on && $urandom_range(0, 99) < 18) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{score: score, node_id: vertex, last: last};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(input int unsigned count, input shape_t shape,
                          input int unsigned spike_pct);
    int base;
    base = $urandom_range(0, 8000000) - 4000000;
    for (int unsigned i = 0; i < count; i++) begin
      send_item(pick_score(shape, base, spike_pct), $urandom(), i == count - 1);
    end
  endtask

  // Registers are only touched once every outstanding result has come back.
  task automatic reconfigure(input logic [CFG_W-1:0] limit,
                             input logic [CFG_W-1:0] factor);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CLOSE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REPORT_LIMIT;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_index <= CFG_DEVIATION_FACTOR;
    cfg_data  <= factor;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned sent;
    int unsigned size;
    int unsigned pick;
    int          base;
    shape_t      shape;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A lone item has no spread, so nothing can stand out.
    send_item(SCORE_MAX, '1, 1'b1);
    send_item(SCORE_MIN, '0, 1'b0);
    send_item(SCORE_MAX, 32'h0000_0001, 1'b1);
    // One spike over a flat floor stands well clear of two sigma.
    for (int i = 0; i < 8; i++) begin
      send_item('0, 32'h10 + i, 1'b0);
    end
    send_item(SCORE_MAX, 32'hA5A5_A5A5, 1'b1);

    // Limit zero acts as one; with k zero anything above the mean qualifies.
    reconfigure(4'd0, 4'd0);
    send_item(-24'sd5, 32'h30, 1'b0);
    send_item(24'sd3, 32'h31, 1'b0);
    send_item(24'sd4, 32'h32, 1'b0);
    send_item(-24'sd1, 32'h33, 1'b1);

    // With k one, a pair sits exactly on the threshold and must not qualify.
    reconfigure(4'd15, 4'd1);
    send_item('0, 32'h20, 1'b0);
    send_item(24'sd4096, 32'h21, 1'b1);
    send_item(24'sd1000, 32'h40, 1'b0);
    send_item(-24'sd1000, 32'h41, 1'b0);
    send_item(24'sd5000, 32'h42, 1'b0);
    send_item(24'sd7000, 32'h43, 1'b0);
    send_item(-24'sd9000, 32'h44, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: reconfigure(4'd1, 4'd0);
        1: reconfigure(4'd10, 4'd15);
        2: reconfigure(4'd15, 4'd0);
        3: reconfigure(4'd0, 4'd3);
        5: reconfigure(4'd10, 4'd1);
        default: reconfigure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 3)));
      endcase
      idle_on = (ph != 4);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        size  = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        pick  = $urandom_range(0, 99);
        shape = (pick < 20) ? SHAPE_NOISE : (pick < 70) ? SHAPE_CLUSTER :
                (pick < 80) ? SHAPE_FLAT : SHAPE_EXTREME;
        send_set(size, shape, 12);
        sent += size;
      end

      base = $urandom_range(0, 4000000) - 4000000;
      if (ph == 1) begin
        // Fifteen sigma needs a set of a few hundred with a single spike.
        for (int i = 0; i < 260; i++) begin
          send_item((i == 130) ? pick_score(SHAPE_FLAT, base + 3000000, 0) :
                    pick_score(SHAPE_CLUSTER, base, 0), $urandom(), i == 259);
        end
      end
    end

    item_valid <= 1'b0;
    idle_on = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d items in %0d sets over %0d register settings,", items_taken,
             sets_closed, settings_used);
    $display("including a fifteen sigma spike, register extremes and exact threshold ties.");
    if (mismatches == 0) begin
      $display("sigma_threshold_outlier_select_tb OK");
    end else begin
      $display("sigma_threshold_outlier_select_tb NOT OK");
    end
    $finish;
  end

endmodule
